// File: hdl/srmd_pkg.sv
package srmd_pkg;

  typedef enum logic [1:0] {
    FUNC_ROTATE = 2'd0,
    FUNC_LEFT   = 2'd1,
    FUNC_RIGHT  = 2'd2
  } func_t;

  localparam int                 Q15_SHIFT      = 15;
  localparam logic [30:0]        Q15_HALF       = 31'd16384;
  localparam logic signed [31:0] Q15_HALF_SQRT2 = 32'sd23170;
  localparam logic [8:0]         DEG_PER_STEP   = 9'd45;
  localparam logic [2:0]         STEP_FWD       = 3'd1;
  localparam logic [2:0]         STEP_BACK      = 3'd7;

  typedef logic [2:0] step_t;

  typedef struct packed {
    logic        rotate;
    step_t       step;
    logic [15:0] dx;
    logic [15:0] dy;
  } item_t;

  typedef struct packed {
    logic [15:0] rx;
    logic [15:0] ry;
    logic [8:0]  deg;
  } result_t;

  // v * 23170 / 32768, rounded half away from zero
  function automatic logic signed [16:0] scale_half(input logic signed [15:0] v);
    logic signed [31:0] prod;
    logic [30:0]        mag;
    logic [30:0]        rnd;
    prod = 32'(v) * Q15_HALF_SQRT2;
    mag  = prod[31] ? 31'(-prod) : 31'(prod);
    rnd  = (mag + Q15_HALF) >> Q15_SHIFT;
    return prod[31] ? -$signed(17'(rnd)) : $signed(17'(rnd));
  endfunction

  function automatic logic [15:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) begin
      return 16'h7fff;
    end else if (v < -18'sd32768) begin
      return 16'h8000;
    end
    return v[15:0];
  endfunction

endpackage

// File: hdl/stepped_rotation_of_motion_delta_core.sv
// an item passes the input register s1 and then the output register, and out_valid
// rises when it reaches the output register; a waiting result can hold it in s1
// throughput: one item per cycle; while a result waits the input register
// still takes one more item, then in_ready stays low until out_ready
// the angle step is updated at input transfer and travels with the item
// reset clears both stage valids and sets the angle to zero degrees
module stepped_rotation_of_motion_delta_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [15:0] delta_x,
  input  logic [15:0] delta_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] turned_x,
  output logic [15:0] turned_y,
  output logic [8:0]  angle_degrees
);
  import srmd_pkg::*;

  logic    s1_valid;
  item_t   s1;
  logic    s2_ready;
  logic    fire;
  step_t   step_next;
  result_t res;

  assign s2_ready = !out_valid || out_ready;
  assign in_ready = !s1_valid || s2_ready;
  assign fire     = in_valid && in_ready;

  srmd_angle u_angle (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .func      (func),
    .step_next (step_next)
  );

  srmd_rotator u_rotator (
    .item (s1),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s2_ready) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1.rotate <= (func == FUNC_ROTATE);
      s1.step   <= step_next;
      s1.dx     <= delta_x;
      s1.dy     <= delta_y;
    end
    if (s1_valid && s2_ready) begin
      turned_x      <= res.rx;
      turned_y      <= res.ry;
      angle_degrees <= res.deg;
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && out_valid)
    else $error("input stalled with a free stage");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s2_ready |=> out_valid)
    else $error("item lost between stages");

  a_identity: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s2_ready && s1.rotate && s1.step == 3'd0
    |=> turned_x == $past(s1.dx) && turned_y == $past(s1.dy) && angle_degrees == 9'd0)
    else $error("zero angle did not pass the delta through");

  a_turn_zero: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s2_ready && !s1.rotate |=> turned_x == 16'h0000 && turned_y == 16'h0000)
    else $error("turn transfer reported a nonzero delta");

endmodule

// File: hdl/srmd_angle.sv
module srmd_angle (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  logic [1:0]           func,
  output srmd_pkg::step_t      step_next
);
  import srmd_pkg::*;

  step_t step;

  always_comb begin
    case (func)
      FUNC_LEFT:  step_next = step + STEP_FWD;
      FUNC_RIGHT: step_next = step + STEP_BACK;
      default:    step_next = step;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (fire) begin
      step <= step_next;
    end
  end

  a_left_turn: assert property (@(posedge clk) disable iff (rst)
    fire && func == FUNC_LEFT |=> step == $past(step) + STEP_FWD)
    else $error("left turn did not advance the angle");

  a_right_turn: assert property (@(posedge clk) disable iff (rst)
    fire && func == FUNC_RIGHT |=> step == $past(step) + STEP_BACK)
    else $error("right turn did not step the angle back");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !fire || func == FUNC_ROTATE |=> $stable(step))
    else $error("angle changed without a turn transfer");

endmodule

// File: hdl/srmd_rotator.sv
module srmd_rotator (
  input  srmd_pkg::item_t   item,
  output srmd_pkg::result_t res
);
  import srmd_pkg::*;

  logic signed [17:0] ex;
  logic signed [17:0] ey;
  logic signed [17:0] hx;
  logic signed [17:0] hy;
  logic signed [17:0] sx;
  logic signed [17:0] sy;

  always_comb begin
    ex = 18'($signed(item.dx));
    ey = 18'($signed(item.dy));
    hx = 18'(scale_half($signed(item.dx)));
    hy = 18'(scale_half($signed(item.dy)));
    // x' = x*c - y*s, y' = x*s + y*c for the eight octants
    case (item.step)
      3'd0:    begin sx = ex;       sy = ey;       end
      3'd1:    begin sx = hx - hy;  sy = hx + hy;  end
      3'd2:    begin sx = -ey;      sy = ex;       end
      3'd3:    begin sx = -hx - hy; sy = hx - hy;  end
      3'd4:    begin sx = -ex;      sy = -ey;      end
      3'd5:    begin sx = hy - hx;  sy = -hx - hy; end
      3'd6:    begin sx = ey;       sy = -ex;      end
      default: begin sx = hx + hy;  sy = hy - hx;  end
    endcase
    res.rx  = item.rotate ? sat16(sx) : 16'h0000;
    res.ry  = item.rotate ? sat16(sy) : 16'h0000;
    res.deg = 9'(item.step) * DEG_PER_STEP;
  end

endmodule
